FILE: src/u8nl_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 decoder with newline normalization.
package u8nl_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;

  localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_LF   = 21'h00000A;
  localparam logic [CP_W-1:0] CP_FF   = 21'h00000C;
  localparam logic [CP_W-1:0] CP_CR   = 21'h00000D;
  localparam logic [CP_W-1:0] CP_NUL  = 21'h000000;

  localparam logic [BYTE_W-1:0] CONT_LO     = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_HI     = 8'hBF;
  localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_MAX   = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX   = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD3_SURR  = 8'hED;
  localparam logic [BYTE_W-1:0] LEAD4_MIN   = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX   = 8'hF4;
  localparam logic [BYTE_W-1:0] E0_LO       = 8'hA0;
  localparam logic [BYTE_W-1:0] ED_HI       = 8'h9F;
  localparam logic [BYTE_W-1:0] F0_LO       = 8'h90;
  localparam logic [BYTE_W-1:0] F4_HI       = 8'h8F;
  localparam logic [BYTE_W-1:0] NUL_BYTE    = 8'h00;

  typedef struct packed {
    logic [CP_W-1:0]   pv;
    logic [1:0]        need;
    logic [1:0]        seen;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic              acr;
    logic              stopped;
  } state_t;

  localparam state_t STATE_RST = '{pv: '0, need: 2'd0, seen: 2'd0, lo: CONT_LO, hi: CONT_HI,
                                   acr: 1'b0, stopped: 1'b0};

  // Results of one byte: count 0..2 and the code points in order
  typedef struct packed {
    logic [1:0]      cnt;
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;
  } res_t;

  typedef struct packed {
    logic            put;
    logic [CP_W-1:0] cp;
    logic            acr;
  } norm_t;

  typedef struct packed {
    logic              emit;
    logic [CP_W-1:0]   cp;
    logic [1:0]        need;
    logic [CP_W-1:0]   pv;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
  } lead_t;

  // Newline normalization of one emitted code point
  function automatic norm_t norm(input logic [CP_W-1:0] cp, input logic acr);
    norm_t r;
    r.put = 1'b1;
    r.cp  = cp;
    r.acr = 1'b0;
    if (cp == CP_FF) begin
      r.cp = CP_LF;
    end else if (cp == CP_CR) begin
      r.cp  = CP_LF;
      r.acr = 1'b1;
    end else if (cp == CP_LF) begin
      r.put = ~acr;
    end else if (cp == CP_NUL) begin
      r.cp = CP_REPL;
    end
    return r;
  endfunction

  // Lead byte handling from a cleared sequence
  function automatic lead_t lead(input logic [BYTE_W-1:0] b);
    lead_t r;
    r.emit = 1'b0;
    r.cp   = '0;
    r.need = 2'd0;
    r.pv   = '0;
    r.lo   = CONT_LO;
    r.hi   = CONT_HI;
    if (b <= ASCII_MAX) begin
      r.emit = 1'b1;
      r.cp   = {{(CP_W-BYTE_W){1'b0}}, b};
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      r.need = 2'd1;
      r.pv   = {{(CP_W-5){1'b0}}, b[4:0]};
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      r.need = 2'd2;
      r.pv   = {{(CP_W-4){1'b0}}, b[3:0]};
      if (b == LEAD3_MIN) begin
        r.lo = E0_LO;
      end else if (b == LEAD3_SURR) begin
        r.hi = ED_HI;
      end
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      r.need = 2'd3;
      r.pv   = {{(CP_W-3){1'b0}}, b[2:0]};
      if (b == LEAD4_MIN) begin
        r.lo = F0_LO;
      end else if (b == LEAD4_MAX) begin
        r.hi = F4_HI;
      end
    end else begin
      r.emit = 1'b1;
      r.cp   = CP_REPL;
    end
    return r;
  endfunction

endpackage

FILE: src/u8nl_in_if.sv
// Byte input channel: valid/ready handshake with one text byte and its end-of-text mark.
interface u8nl_in_if;
  logic                        valid;
  logic                        ready;
  logic [u8nl_pkg::BYTE_W-1:0] data_byte;
  logic                        end_of_text;

  modport source(output valid, output data_byte, output end_of_text, input ready);
  modport sink(input valid, input data_byte, input end_of_text, output ready);
endinterface

FILE: src/u8nl_out_if.sv
// Code point output channel: valid/ready handshake with one code point and a last-of-run flag.
interface u8nl_out_if;
  logic                      valid;
  logic                      ready;
  logic [u8nl_pkg::CP_W-1:0] code_point;
  logic                      last_of_run;

  modport source(output valid, output code_point, output last_of_run, input ready);
  modport sink(input valid, input code_point, input last_of_run, output ready);
endinterface

FILE: src/u8nl_decode.sv
// Decode state register and the per-byte UTF-8 decode and newline normalization logic.
module u8nl_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [u8nl_pkg::BYTE_W-1:0] data_byte,
  input  logic                        end_of_text,
  output u8nl_pkg::res_t              res
);
  import u8nl_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_t          s;
    lead_t           ld;
    norm_t           nm;
    logic            a_vld;
    logic [CP_W-1:0] a_cp;
    logic            b_vld;
    logic            c_vld;
    logic            do_lead;
    logic [1:0]      seen_inc;
    logic [CP_W-1:0] pv_inc;
    logic            acr;
    logic [1:0]      n;
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;

    s        = state_r;
    ld       = lead(data_byte);
    nm       = '0;
    a_vld    = 1'b0;
    a_cp     = CP_REPL;
    do_lead  = 1'b0;
    seen_inc = state_r.seen + 2'd1;
    pv_inc   = {state_r.pv[CP_W-7:0], data_byte[5:0]};

    if (!state_r.stopped) begin
      if (data_byte == NUL_BYTE) begin
        a_vld     = (state_r.need != 2'd0);
        s         = STATE_RST;
        s.acr     = state_r.acr;
        s.stopped = 1'b1;
      end else if (state_r.need == 2'd0) begin
        do_lead = 1'b1;
      end else if (data_byte < state_r.lo || data_byte > state_r.hi) begin
        a_vld   = 1'b1;
        do_lead = 1'b1;
      end else if (seen_inc >= state_r.need) begin
        a_vld = 1'b1;
        a_cp  = pv_inc;
        s     = STATE_RST;
        s.acr = state_r.acr;
      end else begin
        s.lo   = CONT_LO;
        s.hi   = CONT_HI;
        s.pv   = pv_inc;
        s.seen = seen_inc;
      end
    end

    b_vld = do_lead & ld.emit;
    if (do_lead) begin
      s.pv   = ld.pv;
      s.need = ld.need;
      s.seen = 2'd0;
      s.lo   = ld.lo;
      s.hi   = ld.hi;
    end

    c_vld = end_of_text & ~s.stopped & (s.need != 2'd0);

    // Normalize the up to three candidate emissions in order
    acr = state_r.acr;
    n   = 2'd0;
    cp0 = CP_REPL;
    cp1 = CP_REPL;
    if (a_vld) begin
      nm  = norm(a_cp, acr);
      acr = nm.acr;
      if (nm.put) begin
        cp0 = nm.cp;
        n   = 2'd1;
      end
    end
    if (b_vld) begin
      nm  = norm(ld.cp, acr);
      acr = nm.acr;
      if (nm.put) begin
        if (n == 2'd0) begin
          cp0 = nm.cp;
        end else begin
          cp1 = nm.cp;
        end
        n = n + 2'd1;
      end
    end
    if (c_vld && n != 2'd2) begin
      if (n == 2'd0) begin
        cp0 = CP_REPL;
      end else begin
        cp1 = CP_REPL;
      end
      n = n + 2'd1;
    end
    s.acr = acr;

    if (end_of_text) begin
      s = STATE_RST;
    end

    state_nxt = s;
    res.cnt   = n;
    res.cp0   = cp0;
    res.cp1   = cp1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // A stopped decoder produces nothing for any byte
  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && state_r.stopped) |-> (res.cnt == 2'd0))
    else $error("stopped decoder produced a result");

  // End of text leaves the reset state behind
  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && end_of_text) |=> (state_r == STATE_RST))
    else $error("state not reset after end of text");

  // Never more than two results per byte
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (res.cnt != 2'd3))
    else $error("result count out of range");

endmodule

FILE: src/u8nl_outbuf.sv
// Result buffer that holds the results of one byte and hands them out one per transfer.
module u8nl_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  u8nl_pkg::res_t        res,
  output logic                  can_load,
  u8nl_out_if.source            out_if
);
  import u8nl_pkg::*;

  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;
  logic [CP_W-1:0] slot0_r;
  logic [CP_W-1:0] slot1_r;
  logic            xfer;

  assign xfer     = out_if.valid & out_if.ready;
  assign can_load = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_if.ready);

  assign out_if.valid       = (cnt_r != 2'd0);
  assign out_if.code_point  = slot0_r;
  assign out_if.last_of_run = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = res.cnt;
    end else if (xfer) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0_r <= res.cp0;
      slot1_r <= res.cp1;
    end else if (xfer) begin
      slot0_r <= slot1_r;
    end
  end

  // No load while a second result still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !load)
    else $error("result buffer overwritten");

  // A pair of results shows first the non-final one
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.cnt == 2'd2) |=> (out_if.valid && !out_if.last_of_run))
    else $error("pair of results out of order");

  // A byte with no results leaves the output idle
  a_empty_load: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.cnt == 2'd0) |=> !out_if.valid)
    else $error("result shown for a byte without results");

endmodule

FILE: src/utf8_decode_newline_normalize_top.sv
// Top level of the UTF-8 decoder with newline normalization.
//
//  channel   dir  handshake            payload
//  in_if     in   valid/ready          data_byte[7:0], end_of_text
//  out_if    out  valid/ready          code_point[20:0], last_of_run
//
//  Each byte is held in the input register, then decoded combinationally into the result
//  buffer; a byte with one result sustains one byte per cycle while the output is ready.
//  A byte with two results holds the buffer for two output transfers, so the rate is
//  one result per transfer, set by the single output port.
//  rst_n is synchronous; it clears the decode state, the input register and the buffer.
//  Output stalls back up through the result buffer into the input register.
module utf8_decode_newline_normalize_top (
  input  logic       clk,
  input  logic       rst_n,
  u8nl_in_if.sink    in_if,
  u8nl_out_if.source out_if
);
  import u8nl_pkg::*;

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_eot_r;
  logic              can_load;
  logic              fire;
  res_t              res;

  assign fire        = in_vld_r & can_load;
  assign in_if.ready = ~in_vld_r | fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.data_byte;
      in_eot_r  <= in_if.end_of_text;
    end
  end

  u8nl_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .res         (res)
  );

  u8nl_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .res      (res),
    .can_load (can_load),
    .out_if   (out_if)
  );

  // A held input byte is decoded as soon as the buffer can take its results
  a_fire_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_if.valid) |-> fire)
    else $error("input byte held while buffer empty");

endmodule

FILE: tb/sv/tb.sv
// Testbench for utf8_decode_newline_normalize_top: directed and random byte streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8nl_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } cp_expect_t;

  localparam int RAND_BYTES = 300;

  logic clk;
  logic rst_n;

  u8nl_in_if  in_ch();
  u8nl_out_if out_ch();

  utf8_decode_newline_normalize_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // decoder model state
  logic [CP_W-1:0]   acc_val;
  logic [1:0]        acc_need;
  logic [1:0]        acc_seen;
  logic [BYTE_W-1:0] cont_lo;
  logic [BYTE_W-1:0] cont_hi;
  logic              cr_mark;
  logic              halted;

  logic [CP_W-1:0]   step_cps[$];
  cp_expect_t        expected_cps[$];
  logic [BYTE_W-1:0] text_bytes[$];

  int errors       = 0;
  int active_bytes = 0;
  int tx_gap_max   = 19;
  int rx_gap_max   = 19;
  int rx_hold      = 0;
  int rx_wait      = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    if (errors < 40) $display("[tb] mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void append_byte(input logic [BYTE_W-1:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  function automatic void queue_expect(input logic [CP_W-1:0] cp, input logic last);
    cp_expect_t e;
    e.cp   = cp;
    e.last = last;
    expected_cps = {expected_cps, e};
  endfunction

  // ---------------------------------------------------------------- model
  function automatic void put_cp(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] v;
    logic            keep;
    v    = cp;
    keep = 1'b1;
    if (cp == CP_FF || cp == CP_CR) v = CP_LF;
    else if (cp == CP_LF) keep = !cr_mark;
    else if (cp == CP_NUL) v = CP_REPL;
    cr_mark = (cp == CP_CR);
    if (keep && step_cps.size() < 2) step_cps = {step_cps, v};
  endfunction

  function automatic void clear_seq();
    acc_val  = '0;
    acc_need = 2'd0;
    acc_seen = 2'd0;
    cont_lo  = CONT_LO;
    cont_hi  = CONT_HI;
  endfunction

  function automatic void reset_decoder();
    clear_seq();
    cr_mark = 1'b0;
    halted  = 1'b0;
  endfunction

  function automatic void start_seq(input logic [BYTE_W-1:0] b);
    if (b <= ASCII_MAX) begin
      put_cp({{(CP_W-BYTE_W){1'b0}}, b});
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      acc_need = 2'd1;
      acc_val  = {{(CP_W-5){1'b0}}, b[4:0]};
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      acc_need = 2'd2;
      acc_val  = {{(CP_W-4){1'b0}}, b[3:0]};
      if (b == LEAD3_MIN) cont_lo = E0_LO;
      else if (b == LEAD3_SURR) cont_hi = ED_HI;
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      acc_need = 2'd3;
      acc_val  = {{(CP_W-3){1'b0}}, b[2:0]};
      if (b == LEAD4_MIN) cont_lo = F0_LO;
      else if (b == LEAD4_MAX) cont_hi = F4_HI;
    end else begin
      put_cp(CP_REPL);
    end
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
    step_cps.delete();
    if (!halted) begin
      active_bytes++;
      if (b == NUL_BYTE) begin
        if (acc_need != 2'd0) put_cp(CP_REPL);
        clear_seq();
        halted = 1'b1;
      end else if (acc_need == 2'd0) begin
        start_seq(b);
      end else if (b < cont_lo || b > cont_hi) begin
        clear_seq();
        put_cp(CP_REPL);
        start_seq(b);
      end else begin
        cont_lo  = CONT_LO;
        cont_hi  = CONT_HI;
        acc_val  = {acc_val[CP_W-7:0], b[5:0]};
        acc_seen = acc_seen + 2'd1;
        if (acc_seen >= acc_need) begin
          put_cp(acc_val);
          clear_seq();
        end
      end
    end
    if (eot) begin
      if (!halted && acc_need != 2'd0) put_cp(CP_REPL);
      reset_decoder();
    end
    foreach (step_cps[i])
      queue_expect(step_cps[i], (i == step_cps.size() - 1));
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, eot);
  endtask

  task automatic send_queued(input logic eot_at_end);
    foreach (text_bytes[i])
      send_byte(text_bytes[i], eot_at_end && (i == text_bytes.size() - 1));
  endtask

  task automatic stop_and_drain();
    in_ch.valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // receiver: random stalls after each transfer, plus long holds on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) rx_wait = $urandom_range(0, rx_gap_max);
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    cp_expect_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_cps.size() == 0) begin
        report_mismatch($sformatf("unexpected code point %h", out_ch.code_point));
      end else begin
        want = expected_cps.pop_front();
        if (out_ch.code_point !== want.cp)
          report_mismatch($sformatf("code_point %h, expected %h", out_ch.code_point, want.cp));
        if (out_ch.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %b, expected %b for code point %h",
                                    out_ch.last_of_run, want.last, want.cp));
      end
    end
  end

  // ---------------------------------------------------------------- random text
  function automatic logic [BYTE_W-1:0] pick_newline();
    case ($urandom_range(0, 2))
      0:       return BYTE_W'(CP_CR);
      1:       return BYTE_W'(CP_LF);
      default: return BYTE_W'(CP_FF);
    endcase
  endfunction

  task automatic add_sequence(input logic [BYTE_W-1:0] lead, input int conts, input bit spoil);
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] c;
    lo = (lead == LEAD3_MIN) ? E0_LO : (lead == LEAD4_MIN) ? F0_LO : CONT_LO;
    hi = (lead == LEAD3_SURR) ? ED_HI : (lead == LEAD4_MAX) ? F4_HI : CONT_HI;
    append_byte(lead);
    for (int k = 0; k < conts; k++) begin
      if (k == 0) append_byte(BYTE_W'($urandom_range(lo, hi)));
      else append_byte(BYTE_W'($urandom_range(CONT_LO, CONT_HI)));
    end
    if (conts > 0) begin
      lo = CONT_LO;
      hi = CONT_HI;
    end
    if (spoil) begin
      do c = BYTE_W'($urandom_range(1, 255)); while (c >= lo && c <= hi);
      append_byte(c);
    end
  endtask

  task automatic send_random_text(input int units);
    int                kind;
    int                need;
    logic [BYTE_W-1:0] lead;
    text_bytes.delete();
    repeat (units) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        if ($urandom_range(0, 3) == 0) append_byte(pick_newline());
        else append_byte(BYTE_W'($urandom_range(1, ASCII_MAX)));
      end else if (kind < 80) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       lead = LEAD3_MIN;
            1:       lead = LEAD3_SURR;
            2:       lead = LEAD4_MIN;
            default: lead = LEAD4_MAX;
          endcase
        end else begin
          lead = BYTE_W'($urandom_range(LEAD2_MIN, LEAD4_MAX));
        end
        need = (lead >= LEAD4_MIN) ? 3 : (lead >= LEAD3_MIN) ? 2 : 1;
        if (kind < 66) add_sequence(lead, need, 1'b0);
        else if (kind < 73) add_sequence(lead, $urandom_range(0, need - 1), 1'b0);
        else add_sequence(lead, $urandom_range(0, need - 1), 1'b1);
      end else if (kind < 97) begin
        if ($urandom_range(0, 1) == 0)
          append_byte(BYTE_W'($urandom_range(CONT_LO, LEAD2_MIN - 1)));
        else
          append_byte(BYTE_W'($urandom_range(LEAD4_MAX + 1, 8'hFF)));
      end else begin
        append_byte(NUL_BYTE);
      end
    end
    send_queued(1'b1);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_ascii_limits();
    text_bytes = {8'h01, 8'h41, ASCII_MAX};
    send_queued(1'b1);
    stop_and_drain();
  endtask

  task automatic test_multibyte_forms();
    text_bytes = {LEAD2_MIN, CONT_LO,
                  LEAD3_MIN, E0_LO, CONT_LO,
                  LEAD3_SURR, ED_HI, CONT_HI,
                  LEAD4_MAX, F4_HI, CONT_HI, CONT_HI};
    send_queued(1'b1);
    stop_and_drain();
  endtask

  task automatic test_invalid_bytes();
    // bad leads, then continuations outside the narrowed ranges
    text_bytes = {CONT_LO, LEAD2_MIN - 8'd1, LEAD4_MAX + 8'd1, 8'hFF,
                  LEAD3_MIN, 8'h9F, LEAD3_SURR, 8'hA0, LEAD2_MIN, 8'h41};
    send_queued(1'b1);
    stop_and_drain();
  endtask

  task automatic test_newlines();
    // CR LF, CR CR LF, FF, and a CR whose mark is cleared by a multibyte code point
    text_bytes = {8'h0D, 8'h0A, 8'h0D, 8'h0D, 8'h0A, 8'h0C, 8'h41,
                  8'h0D, LEAD2_MIN, CONT_LO, 8'h0A};
    send_queued(1'b1);
    stop_and_drain();
  endtask

  task automatic test_nul_and_end();
    text_bytes = {8'hE2, 8'h82};
    send_queued(1'b1);
    text_bytes = {LEAD2_MIN, 8'hE2};
    send_queued(1'b1);
    text_bytes = {LEAD2_MIN, NUL_BYTE, 8'h41, 8'h0D, LEAD2_MIN};
    send_queued(1'b1);
    text_bytes = {8'h0D, LEAD4_MIN, F0_LO, NUL_BYTE};
    send_queued(1'b1);
    text_bytes = {8'h0D};
    send_queued(1'b1);
    text_bytes = {8'h0A};
    send_queued(1'b1);
    stop_and_drain();
  endtask

  task automatic test_output_stall();
    tx_gap_max = 0;
    rx_hold    = 60;
    send_random_text(30);
    stop_and_drain();
    tx_gap_max = 19;
  endtask

  task automatic test_random_text();
    active_bytes = 0;
    while (active_bytes < RAND_BYTES) begin
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      send_random_text($urandom_range(1, 24));
    end
    stop_and_drain();
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.end_of_text <= 1'b0;
    reset_decoder();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_ascii_limits();
    test_multibyte_forms();
    test_invalid_bytes();
    test_newlines();
    test_nul_and_end();
    test_output_stall();
    test_random_text();

    if (errors == 0) begin
      $display("[utf8_decode_newline_normalize_top] OK");
    end else begin
      $display("[utf8_decode_newline_normalize_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[tb] timeout");
    $display("[utf8_decode_newline_normalize_top] ERROR");
    $finish;
  end

endmodule
